FILE: sv/imu_stc_pkg.sv
// Package: shared widths and the trim bound function of the IMU self-test checker.
`timescale 1ns / 1ps

package imu_stc_pkg;

  // Fixed field widths
  localparam int RESP_W   = 16;
  localparam int CODE_W   = 5;
  localparam int NCODES   = 32;
  localparam int NAXES    = 3;
  localparam int MASK_W   = 6;
  localparam int TRIM_Q   = 20;

  // Default fraction bits of the bound tables
  localparam int BOUND_FRAC_BITS_DEF = 8;

  // Table selectors
  localparam bit SENS_GYRO  = 1'b1;
  localparam bit SENS_ACCEL = 1'b0;
  localparam bit BOUND_LO   = 1'b0;
  localparam bit BOUND_HI   = 1'b1;

  // Factory trim bound for one code, in Q(bf). Evaluated at elaboration only;
  // the result is a ROM entry.
  function automatic logic [63:0] trim_bound(input bit is_gyro, input int code,
                                             input int bf, input bit hi_side);
    logic [63:0] t;
    logic [63:0] g;
    logic [63:0] lo;
    logic [63:0] hi;
    logic [63:0] mid;
    logic [63:0] target;
    logic [63:0] p;
    logic [63:0] q;
    logic [63:0] rnd;
    bit          ok;
    int          c;
    int          k;
    int          sh;
    if (code == 0) begin
      return 64'd0;
    end
    if (is_gyro) begin
      // 3275 grown by 1.046 per code, rounded down each step
      t = 64'd3275 << TRIM_Q;
      for (c = 1; c <= code; c++) begin
        t = (t * 64'd523) / 64'd500;
      end
    end else begin
      // Q30 thirtieth root of 46/17 by bisection
      target = (64'd46 << 30) / 64'd17;
      lo = 64'd1 << 30;
      hi = 64'd1 << 31;
      while (hi - lo > 64'd1) begin
        mid = lo + ((hi - lo) >> 1);
        p   = 64'd1 << 30;
        ok  = 1'b1;
        for (k = 0; k < 30; k++) begin
          if (ok) begin
            p = (p * mid) >> 30;
            if (p > target) begin
              ok = 1'b0;
            end
          end
        end
        if (ok) begin
          lo = mid;
        end else begin
          hi = mid;
        end
      end
      g = lo;
      t = (64'd139264 << TRIM_Q) / 64'd100;
      for (c = 2; c <= code; c++) begin
        t = (t * g) >> 30;
      end
    end
    // scale from Q20 to Q(bf): floor or ceil of x / (100 * 2^sh)
    sh = TRIM_Q - bf;
    if (hi_side) begin
      q = (t * 64'd114) / 64'd100;
      return q >> sh;
    end else begin
      q   = (t * 64'd86 + 64'd99) / 64'd100;
      rnd = (64'd1 << sh) - 64'd1;
      return (q + rnd) >> sh;
    end
  endfunction

endpackage

FILE: sv/imu_stc_if.sv
// Interfaces: check item input channel and fail mask result channel.
`timescale 1ns / 1ps

interface imu_stc_in_if;
  logic        valid;
  logic        ready;
  logic signed [imu_stc_pkg::RESP_W-1:0] gyro_resp_x;
  logic signed [imu_stc_pkg::RESP_W-1:0] gyro_resp_y;
  logic signed [imu_stc_pkg::RESP_W-1:0] gyro_resp_z;
  logic signed [imu_stc_pkg::RESP_W-1:0] accel_resp_x;
  logic signed [imu_stc_pkg::RESP_W-1:0] accel_resp_y;
  logic signed [imu_stc_pkg::RESP_W-1:0] accel_resp_z;
  logic [7:0]  trim_byte_x;
  logic [7:0]  trim_byte_y;
  logic [7:0]  trim_byte_z;
  logic [7:0]  trim_byte_a;

  modport source (
    output valid, gyro_resp_x, gyro_resp_y, gyro_resp_z,
    output accel_resp_x, accel_resp_y, accel_resp_z,
    output trim_byte_x, trim_byte_y, trim_byte_z, trim_byte_a,
    input  ready
  );
  modport sink (
    input  valid, gyro_resp_x, gyro_resp_y, gyro_resp_z,
    input  accel_resp_x, accel_resp_y, accel_resp_z,
    input  trim_byte_x, trim_byte_y, trim_byte_z, trim_byte_a,
    output ready
  );
endinterface

interface imu_stc_out_if;
  logic        valid;
  logic        ready;
  logic [imu_stc_pkg::MASK_W-1:0] fail_mask;

  modport source (output valid, fail_mask, input ready);
  modport sink (input valid, fail_mask, output ready);
endinterface

FILE: sv/imu_stc_lane.sv
// One axis lane: bound ROM lookup by trim code and window compare.
`timescale 1ns / 1ps

module imu_stc_lane #(
  parameter bit IS_GYRO         = imu_stc_pkg::SENS_GYRO,
  parameter int BOUND_FRAC_BITS = imu_stc_pkg::BOUND_FRAC_BITS_DEF
) (
  input  logic signed [imu_stc_pkg::RESP_W:0]   resp,   // already sign-corrected
  input  logic        [imu_stc_pkg::CODE_W-1:0] code,
  output logic                                  fail
);

  localparam int RW = imu_stc_pkg::RESP_W + 2 + BOUND_FRAC_BITS;

  logic [RW-1:0] lo_tab [imu_stc_pkg::NCODES];
  logic [RW-1:0] hi_tab [imu_stc_pkg::NCODES];
  logic signed [RW-1:0] rs;
  logic signed [RW-1:0] lo_s;
  logic signed [RW-1:0] hi_s;

  // bound ROMs, built at elaboration
  for (genvar c = 0; c < imu_stc_pkg::NCODES; c++) begin : g_rom
    assign lo_tab[c] = RW'(imu_stc_pkg::trim_bound(IS_GYRO, c, BOUND_FRAC_BITS,
                                                   imu_stc_pkg::BOUND_LO));
    assign hi_tab[c] = RW'(imu_stc_pkg::trim_bound(IS_GYRO, c, BOUND_FRAC_BITS,
                                                   imu_stc_pkg::BOUND_HI));
  end

  // scaled response against the window; code zero only passes a zero response
  always_comb begin
    rs   = RW'(resp) <<< BOUND_FRAC_BITS;
    lo_s = $signed(lo_tab[code]);
    hi_s = $signed(hi_tab[code]);
    if (code == '0) begin
      fail = (resp != '0);
    end else begin
      fail = (rs < lo_s) || (rs > hi_s);
    end
  end

endmodule

FILE: sv/imu_stc_merge.sv
// Merge stage: gathers lane fail bits into the mask and holds the output register.
`timescale 1ns / 1ps

module imu_stc_merge (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [imu_stc_pkg::NAXES-1:0]  gyro_fail,
  input  logic [imu_stc_pkg::NAXES-1:0]  accel_fail,
  imu_stc_out_if.source                  out_ch
);

  logic                           valid_r;
  logic                           valid_nxt;
  logic [imu_stc_pkg::MASK_W-1:0] mask_r;
  logic [imu_stc_pkg::MASK_W-1:0] mask_nxt;
  logic                           in_fire;

  // take a new beat whenever the output slot is empty or draining
  assign in_ready = !valid_r || out_ch.ready;
  assign in_fire  = in_valid && in_ready;

  // lane order: X at the high end of each half
  always_comb begin
    mask_nxt = {gyro_fail[0], gyro_fail[1], gyro_fail[2],
                accel_fail[0], accel_fail[1], accel_fail[2]};
    if (in_fire) begin
      valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      valid_nxt = 1'b0;
    end else begin
      valid_nxt = valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (in_fire) begin
      mask_r <= mask_nxt;
    end
  end

  assign out_ch.valid     = valid_r;
  assign out_ch.fail_mask = mask_r;

`ifndef NO_ASSERTIONS
  a_fire_shows: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> valid_r)
    else $error("accepted beat not presented");
  a_no_overwrite: assert property (@(posedge clk) disable iff (!rst_n)
    (valid_r && !out_ch.ready) |-> !in_ready)
    else $error("held result could be overwritten");
  a_mask_loaded: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire |=> (mask_r == $past(mask_nxt)))
    else $error("mask register not loaded from lanes");
`endif

endmodule

FILE: sv/imu_stc_top_lanes.sv
// Lane array: unpacks trim codes and runs the six axis lanes in parallel.
`timescale 1ns / 1ps

module imu_stc_top_lanes #(
  parameter int BOUND_FRAC_BITS = imu_stc_pkg::BOUND_FRAC_BITS_DEF
) (
  input  logic signed [imu_stc_pkg::RESP_W-1:0] gyro_resp  [imu_stc_pkg::NAXES],
  input  logic signed [imu_stc_pkg::RESP_W-1:0] accel_resp [imu_stc_pkg::NAXES],
  input  logic        [7:0]                     trim_byte  [imu_stc_pkg::NAXES],
  input  logic        [7:0]                     trim_byte_a,
  output logic        [imu_stc_pkg::NAXES-1:0]  gyro_fail,
  output logic        [imu_stc_pkg::NAXES-1:0]  accel_fail
);

  for (genvar i = 0; i < imu_stc_pkg::NAXES; i++) begin : g_axis
    logic signed [imu_stc_pkg::RESP_W:0]   g_resp;
    logic signed [imu_stc_pkg::RESP_W:0]   a_resp;
    logic        [imu_stc_pkg::CODE_W-1:0] g_code;
    logic        [imu_stc_pkg::CODE_W-1:0] a_code;

    // gyro Y trim is negative: flip the response instead
    if (i == 1) begin : g_neg
      assign g_resp = -((imu_stc_pkg::RESP_W + 1)'(gyro_resp[i]));
    end else begin : g_pos
      assign g_resp = (imu_stc_pkg::RESP_W + 1)'(gyro_resp[i]);
    end
    assign a_resp = (imu_stc_pkg::RESP_W + 1)'(accel_resp[i]);

    // trim code unpack
    assign g_code = trim_byte[i][4:0];
    assign a_code = {trim_byte[i][7:5], trim_byte_a[5 - 2 * i -: 2]};

    imu_stc_lane #(
      .IS_GYRO         (imu_stc_pkg::SENS_GYRO),
      .BOUND_FRAC_BITS (BOUND_FRAC_BITS)
    ) u_gyro (
      .resp (g_resp),
      .code (g_code),
      .fail (gyro_fail[i])
    );

    imu_stc_lane #(
      .IS_GYRO         (imu_stc_pkg::SENS_ACCEL),
      .BOUND_FRAC_BITS (BOUND_FRAC_BITS)
    ) u_accel (
      .resp (a_resp),
      .code (a_code),
      .fail (accel_fail[i])
    );
  end

endmodule

FILE: sv/imu_self_test_checker_core.sv
// An accepted check beat's fail mask is on the output in the cycle after it is accepted.
// Throughput: one check per cycle while the output register is empty or being taken;
// the six axis lanes are combinational ROM lookups and compares ahead of a single output register.
// Input ready stays high while the output register is empty or being taken.
// Reset (rst_n low, synchronous) clears the output valid; bound ROMs are constant.
`timescale 1ns / 1ps

module imu_self_test_checker_core #(
  parameter int BOUND_FRAC_BITS = imu_stc_pkg::BOUND_FRAC_BITS_DEF
) (
  input  logic          clk,
  input  logic          rst_n,
  imu_stc_in_if.sink    in_ch,
  imu_stc_out_if.source out_ch
);

  logic signed [imu_stc_pkg::RESP_W-1:0] gyro_resp  [imu_stc_pkg::NAXES];
  logic signed [imu_stc_pkg::RESP_W-1:0] accel_resp [imu_stc_pkg::NAXES];
  logic        [7:0]                     trim_byte  [imu_stc_pkg::NAXES];
  logic        [imu_stc_pkg::NAXES-1:0]  gyro_fail;
  logic        [imu_stc_pkg::NAXES-1:0]  accel_fail;
  logic                                  in_ready;

  // per-axis views of the beat
  assign gyro_resp[0]  = in_ch.gyro_resp_x;
  assign gyro_resp[1]  = in_ch.gyro_resp_y;
  assign gyro_resp[2]  = in_ch.gyro_resp_z;
  assign accel_resp[0] = in_ch.accel_resp_x;
  assign accel_resp[1] = in_ch.accel_resp_y;
  assign accel_resp[2] = in_ch.accel_resp_z;
  assign trim_byte[0]  = in_ch.trim_byte_x;
  assign trim_byte[1]  = in_ch.trim_byte_y;
  assign trim_byte[2]  = in_ch.trim_byte_z;

  imu_stc_top_lanes #(
    .BOUND_FRAC_BITS (BOUND_FRAC_BITS)
  ) u_lanes (
    .gyro_resp   (gyro_resp),
    .accel_resp  (accel_resp),
    .trim_byte   (trim_byte),
    .trim_byte_a (in_ch.trim_byte_a),
    .gyro_fail   (gyro_fail),
    .accel_fail  (accel_fail)
  );

  imu_stc_merge u_merge (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_ch.valid),
    .in_ready   (in_ready),
    .gyro_fail  (gyro_fail),
    .accel_fail (accel_fail),
    .out_ch     (out_ch)
  );

  assign in_ch.ready = in_ready;

endmodule

FILE: verif/tb_imu_self_test_checker_core.sv
// IMU self-test checker testbench: directed and random beats scored against its own bound tables.
`timescale 1ns / 1ps

module tb_imu_self_test_checker_core;
  import imu_stc_pkg::*;

  localparam int BOUND_FRAC  = BOUND_FRAC_BITS_DEF;
  localparam int N_RANDOM    = 1200;
  localparam int CYCLE_LIMIT = 200000;

  // One check beat; index 0/1/2 is axis X/Y/Z
  typedef struct packed {
    logic [2:0][RESP_W-1:0] gyro;
    logic [2:0][RESP_W-1:0] accel;
    logic [2:0][7:0]        trim;
    logic [7:0]             trim_a;
  } check_t;

  // Receiver stall patterns, rotated in turn by the receiver's counter
  typedef enum logic [1:0] {RX_OPEN, RX_RANDOM, RX_PERIODIC, RX_BLOCKED} rx_mode_e;

  logic clk;
  logic rst_n;

  imu_stc_in_if  in_ch ();
  imu_stc_out_if out_ch ();

  imu_self_test_checker_core #(
    .BOUND_FRAC_BITS(BOUND_FRAC)
  ) DUT (
    .clk    (clk),
    .rst_n  (rst_n),
    .in_ch  (in_ch),
    .out_ch (out_ch)
  );

  // Bound tables in Q(BOUND_FRAC), indexed by trim code
  longint gyro_lo [NCODES];
  longint gyro_hi [NCODES];
  longint accel_lo[NCODES];
  longint accel_hi[NCODES];

  check_t            pending_checks[$];
  logic [MASK_W-1:0] expected_masks[$];
  check_t            drv_item;
  check_t            seen_item;
  logic [MASK_W-1:0] want_mask;
  logic [MASK_W-1:0] pred_mask;
  int                burst_left;
  int                gap_left;
  int                beats_sent;
  int                masks_checked;
  int                directed_count;
  int                errors;
  int                cycle_count;
  int                axis_fail_seen[MASK_W];
  logic [11:0]       rx_cnt;

  // Clock
  initial clk = 1'b0;
  always begin
    #4 clk = 1'b1;
    #4 clk = 1'b0;
  end

  // One axis against its band; code zero only passes a zero response
  function automatic bit out_of_band(longint resp, int code, bit is_gyro);
    longint scaled;
    longint lo_b;
    longint hi_b;
    if (code == 0) begin
      return resp != 0;
    end
    scaled = resp * (longint'(1) << BOUND_FRAC);
    lo_b   = is_gyro ? gyro_lo[code] : accel_lo[code];
    hi_b   = is_gyro ? gyro_hi[code] : accel_hi[code];
    return (scaled < lo_b) || (scaled > hi_b);
  endfunction

  function automatic logic [MASK_W-1:0] predict_fail_mask(check_t c);
    logic [MASK_W-1:0] m;
    longint            gr;
    longint            ar;
    int                gcode;
    int                acode;
    int                i;
    m = '0;
    for (i = 0; i < NAXES; i++) begin
      gcode = c.trim[i][4:0];
      acode = {c.trim[i][7:5], c.trim_a[5-2*i -: 2]};
      gr    = longint'($signed(c.gyro[i]));
      ar    = longint'($signed(c.accel[i]));
      // gyro Y trim is negative: flip the response onto the positive bounds
      if (i == 1) begin
        gr = -gr;
      end
      if (out_of_band(gr, gcode, 1'b1)) begin
        m[5-i] = 1'b1;
      end
      if (out_of_band(ar, acode, 1'b0)) begin
        m[2-i] = 1'b1;
      end
    end
    return m;
  endfunction

  // Response at or just past a band edge: 0 low edge, 1 below, 2 high edge, 3 above
  function automatic int band_edge(bit is_gyro, int code, int which);
    longint lo_r;
    longint hi_r;
    lo_r = ((is_gyro ? gyro_lo[code] : accel_lo[code]) + (longint'(1) << BOUND_FRAC) - 1)
           >>> BOUND_FRAC;
    hi_r = (is_gyro ? gyro_hi[code] : accel_hi[code]) >>> BOUND_FRAC;
    case (which)
      0: begin
        return int'(lo_r);
      end
      1: begin
        return int'(lo_r - 1);
      end
      2: begin
        return int'(hi_r);
      end
      default: begin
        return int'(hi_r + 1);
      end
    endcase
  endfunction

  function automatic check_t with_axis(check_t c, int i, int gcode, int acode,
                                       int gresp, int aresp);
    c.trim[i]             = {acode[4:2], gcode[4:0]};
    c.trim_a[5-2*i -: 2]  = acode[1:0];
    c.gyro[i]             = gresp[RESP_W-1:0];
    c.accel[i]            = aresp[RESP_W-1:0];
    return c;
  endfunction

  // Same codes and response on every axis; gyro Y gets the negated response
  function automatic check_t uniform_check(int gcode, int acode, int gv, int av,
                                           logic [1:0] top);
    check_t c;
    int     i;
    c = '0;
    for (i = 0; i < NAXES; i++) begin
      c = with_axis(c, i, gcode, acode, (i == 1) ? -gv : gv, av);
    end
    c.trim_a[7:6] = top;
    return c;
  endfunction

  // Code and response for one axis: mostly near the band, some code zero and noise
  function automatic void pick_axis(input bit is_gyro, output int code, output int resp);
    int k;
    int lo_r;
    int hi_r;
    k = $urandom_range(19);
    if (k == 0) begin
      code = 0;
      resp = 0;
    end else if (k == 1) begin
      code = 0;
      resp = int'($signed(16'($urandom)));
    end else if (k == 2) begin
      code = $urandom_range(NCODES - 1);
      resp = int'($signed(16'($urandom)));
    end else begin
      code = $urandom_range(NCODES - 1, 1);
      k    = $urandom_range(9);
      if (k < 4) begin
        resp = band_edge(is_gyro, code, k);
      end else begin
        lo_r = band_edge(is_gyro, code, 0);
        hi_r = band_edge(is_gyro, code, 2);
        resp = lo_r - 20 + int'($urandom_range(hi_r - lo_r + 40));
      end
    end
  endfunction

  function automatic check_t random_check();
    check_t c;
    int     gc;
    int     ac;
    int     gv;
    int     av;
    int     i;
    if ($urandom_range(9) == 0) begin
      c = {$urandom, $urandom, $urandom, $urandom};
    end else begin
      c = '0;
      for (i = 0; i < NAXES; i++) begin
        pick_axis(1'b1, gc, gv);
        pick_axis(1'b0, ac, av);
        c = with_axis(c, i, gc, ac, (i == 1) ? -gv : gv, av);
      end
      c.trim_a[7:6] = 2'($urandom_range(3));
    end
    return c;
  endfunction

  // Sender: bursts of beats with random gaps, fed from pending_checks
  always @(posedge clk) begin
    if (!rst_n) begin
      in_ch.valid <= 1'b0;
      burst_left = $urandom_range(16, 1);
      gap_left   = 0;
    end else begin
      if (in_ch.valid && in_ch.ready) begin
        seen_item.gyro[0]  = in_ch.gyro_resp_x;
        seen_item.gyro[1]  = in_ch.gyro_resp_y;
        seen_item.gyro[2]  = in_ch.gyro_resp_z;
        seen_item.accel[0] = in_ch.accel_resp_x;
        seen_item.accel[1] = in_ch.accel_resp_y;
        seen_item.accel[2] = in_ch.accel_resp_z;
        seen_item.trim[0]  = in_ch.trim_byte_x;
        seen_item.trim[1]  = in_ch.trim_byte_y;
        seen_item.trim[2]  = in_ch.trim_byte_z;
        seen_item.trim_a   = in_ch.trim_byte_a;
        pred_mask = predict_fail_mask(seen_item);
        expected_masks.push_back(pred_mask);
        for (int b = 0; b < MASK_W; b++) begin
          axis_fail_seen[b] += pred_mask[b];
        end
        beats_sent++;
      end
      if (!in_ch.valid || in_ch.ready) begin
        if (gap_left > 0) begin
          in_ch.valid <= 1'b0;
          gap_left--;
        end else if (pending_checks.size() > 0) begin
          drv_item = pending_checks.pop_front();
          in_ch.gyro_resp_x  <= drv_item.gyro[0];
          in_ch.gyro_resp_y  <= drv_item.gyro[1];
          in_ch.gyro_resp_z  <= drv_item.gyro[2];
          in_ch.accel_resp_x <= drv_item.accel[0];
          in_ch.accel_resp_y <= drv_item.accel[1];
          in_ch.accel_resp_z <= drv_item.accel[2];
          in_ch.trim_byte_x  <= drv_item.trim[0];
          in_ch.trim_byte_y  <= drv_item.trim[1];
          in_ch.trim_byte_z  <= drv_item.trim[2];
          in_ch.trim_byte_a  <= drv_item.trim_a;
          in_ch.valid        <= 1'b1;
          if (burst_left <= 1) begin
            burst_left = $urandom_range(16, 1);
            gap_left   = ($urandom_range(2) == 0) ? 0 : $urandom_range(6, 1);
          end else begin
            burst_left--;
          end
        end else begin
          in_ch.valid <= 1'b0;
        end
      end
    end
  end

  // Receiver stall pattern
  always @(posedge clk) begin
    if (!rst_n) begin
      out_ch.ready <= 1'b0;
      rx_cnt       <= '0;
    end else begin
      rx_cnt <= rx_cnt + 1'b1;
      case (rx_mode_e'(rx_cnt[9:8]))
        RX_OPEN: begin
          out_ch.ready <= 1'b1;
        end
        RX_RANDOM: begin
          out_ch.ready <= ($urandom_range(9) < 7);
        end
        RX_PERIODIC: begin
          out_ch.ready <= (rx_cnt[1:0] != 2'd3);
        end
        default: begin
          out_ch.ready <= (rx_cnt[4:3] == 2'd0);
        end
      endcase
    end
  end

  // Result monitor: each fail mask against the oldest prediction
  always @(posedge clk) begin
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (expected_masks.size() == 0) begin
        $display("%0t: unexpected fail_mask beat: expected none, actual %b",
                 $time, out_ch.fail_mask);
        errors++;
      end else begin
        want_mask = expected_masks.pop_front();
        if (out_ch.fail_mask !== want_mask) begin
          $display("%0t: fail_mask mismatch: expected %b, actual %b",
                   $time, want_mask, out_ch.fail_mask);
          errors++;
        end
        masks_checked++;
      end
    end
  end

  // Watchdog
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("%0t: timeout after %0d cycles, %0d fail masks outstanding",
               $time, cycle_count, expected_masks.size());
      $display("CHECKS FAILED");
      $finish;
    end
  end

  // Tables, stimulus, reset and end of run
  initial begin
    bit [63:0] t;
    bit [63:0] g;
    bit [63:0] lo_g;
    bit [63:0] hi_g;
    bit [63:0] mid;
    bit [63:0] target;
    bit [63:0] p;
    bit [63:0] div;
    bit        ok;
    int        c;
    int        k;
    int        ac;
    int        n_total;
    check_t    item;

    rst_n          = 1'b0;
    in_ch.valid    = 1'b0;
    in_ch.gyro_resp_x  = '0;
    in_ch.gyro_resp_y  = '0;
    in_ch.gyro_resp_z  = '0;
    in_ch.accel_resp_x = '0;
    in_ch.accel_resp_y = '0;
    in_ch.accel_resp_z = '0;
    in_ch.trim_byte_x  = '0;
    in_ch.trim_byte_y  = '0;
    in_ch.trim_byte_z  = '0;
    in_ch.trim_byte_a  = '0;
    out_ch.ready   = 1'b0;
    errors         = 0;
    beats_sent     = 0;
    masks_checked  = 0;
    cycle_count    = 0;
    for (k = 0; k < MASK_W; k++) begin
      axis_fail_seen[k] = 0;
    end

    // Gyro trims: 3275 in Q20, times 1.046 per code, floored each step
    div = 64'd100 << (TRIM_Q - BOUND_FRAC);
    gyro_lo[0]  = 0;
    gyro_hi[0]  = 0;
    accel_lo[0] = 0;
    accel_hi[0] = 0;
    t = 64'd3275 << TRIM_Q;
    for (c = 1; c < NCODES; c++) begin
      t = (t * 64'd523) / 64'd500;
      gyro_lo[c] = longint'((t * 64'd86 + div - 64'd1) / div);
      gyro_hi[c] = longint'((t * 64'd114) / div);
    end

    // Accel step: largest Q30 g whose floored 30th power stays within 46/17
    target = (64'd46 << 30) / 64'd17;
    lo_g   = 64'd1 << 30;
    hi_g   = 64'd1 << 31;
    while (hi_g - lo_g > 64'd1) begin
      mid = lo_g + ((hi_g - lo_g) >> 1);
      p   = 64'd1 << 30;
      ok  = 1'b1;
      for (k = 0; k < 30 && ok; k++) begin
        p = (p * mid) >> 30;
        if (p > target) begin
          ok = 1'b0;
        end
      end
      if (ok) begin
        lo_g = mid;
      end else begin
        hi_g = mid;
      end
    end
    g = lo_g;
    t = (64'd139264 << TRIM_Q) / 64'd100;
    for (c = 1; c < NCODES; c++) begin
      if (c > 1) begin
        t = (t * g) >> 30;
      end
      accel_lo[c] = longint'((t * 64'd86 + div - 64'd1) / div);
      accel_hi[c] = longint'((t * 64'd114) / div);
    end

    // Directed: code zero, field extremes, band edges, wrong signs, unused bits
    pending_checks.push_back(uniform_check(0, 0, 0, 0, 2'b00));
    pending_checks.push_back(uniform_check(0, 0, 1, -1, 2'b11));
    pending_checks.push_back(uniform_check(31, 31, 32767, 32767, 2'b00));
    pending_checks.push_back(uniform_check(31, 31, -32768, -32768, 2'b10));
    for (c = 1; c < NCODES; c += 15) begin
      ac = (c == 1) ? 31 : ((c == 31) ? 1 : c);
      for (k = 0; k < 4; k++) begin
        pending_checks.push_back(uniform_check(c, ac, band_edge(1'b1, c, k),
                                               band_edge(1'b0, ac, k), 2'(k)));
      end
    end
    // negative responses on positive trims
    pending_checks.push_back(uniform_check(10, 10, -band_edge(1'b1, 10, 0),
                                           -band_edge(1'b0, 10, 0), 2'b01));
    // gyro Y with a positive response
    item = uniform_check(20, 20, band_edge(1'b1, 20, 0), band_edge(1'b0, 20, 2), 2'b00);
    item = with_axis(item, 1, 20, 20, band_edge(1'b1, 20, 2), band_edge(1'b0, 20, 2));
    pending_checks.push_back(item);
    // mixed codes per axis, code zero next to live codes
    item = '0;
    item = with_axis(item, 0, 5, 0, band_edge(1'b1, 5, 2), 0);
    item = with_axis(item, 1, 0, 7, 0, band_edge(1'b0, 7, 0));
    item = with_axis(item, 2, 31, 31, band_edge(1'b1, 31, 3), band_edge(1'b0, 31, 1));
    item.trim_a[7:6] = 2'b11;
    pending_checks.push_back(item);
    // every trim bit set
    item = uniform_check(31, 31, band_edge(1'b1, 31, 0), band_edge(1'b0, 31, 2), 2'b11);
    pending_checks.push_back(item);
    directed_count = pending_checks.size();

    for (k = 0; k < N_RANDOM; k++) begin
      pending_checks.push_back(random_check());
    end
    n_total = pending_checks.size();

    repeat (11) @(posedge clk);
    rst_n <= 1'b1;

    // Drain: every beat accepted and every mask back, then a quiet wait before the summary
    while (beats_sent < n_total || expected_masks.size() != 0) begin
      @(posedge clk);
    end
    repeat (8) @(posedge clk);

    $display("Summary: %0d check beats (%0d directed), %0d fail masks compared",
             beats_sent, directed_count, masks_checked);
    $display("Axis fails predicted: gx %0d gy %0d gz %0d ax %0d ay %0d az %0d",
             axis_fail_seen[5], axis_fail_seen[4], axis_fail_seen[3],
             axis_fail_seen[2], axis_fail_seen[1], axis_fail_seen[0]);
    if (errors == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

FILE: files.f
sv/imu_stc_pkg.sv
sv/imu_stc_if.sv
sv/imu_stc_lane.sv
sv/imu_stc_merge.sv
sv/imu_stc_top_lanes.sv
sv/imu_self_test_checker_core.sv
verif/tb_imu_self_test_checker_core.sv
